// ===== sv/oca_pkg.sv =====
`default_nettype none
package oca_pkg;

  localparam int MAX_SLOTS           = 16;
  localparam int SAMPLE_BITS         = 10;
  localparam int MAX_OVERSAMPLE_BITS = 16;
  localparam int SUM_BITS            = SAMPLE_BITS + MAX_OVERSAMPLE_BITS;
  localparam int SLOT_W              = $clog2(MAX_SLOTS);
  localparam int SET_CNT_W           = MAX_OVERSAMPLE_BITS + 1;
  localparam int CFG_W               = 5;
  localparam int AVG_W               = 10;
  localparam int PADDR_W             = 3;
  localparam int PDATA_W             = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ACTIVE_SLOTS    = 1'b0;
  localparam logic REG_OVERSAMPLE_BITS = 1'b1;

  typedef logic [SUM_BITS-1:0] sum_t;
  typedef logic [SLOT_W-1:0]   slot_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } oca_state_t;

endpackage
`default_nettype wire

// ===== sv/oca_sum_ram.sv =====
`default_nettype none
module oca_sum_ram import oca_pkg::*; (
  input  wire logic      clk,
  input  wire logic      we,
  input  wire slot_idx_t waddr,
  input  wire sum_t      wdata,
  input  wire slot_idx_t raddr,
  output sum_t           rdata
);

  sum_t mem [MAX_SLOTS];
  sum_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/oversampling_channel_averager.sv =====
// A sample is summed in ST_ACCUM, the cycle after acceptance; no new sample is
// taken while it is summed. A set's results follow the sample that completes it:
// each is read from the sum RAM in ST_EMIT_RD and loaded out in ST_EMIT_OUT,
// which waits while the output stalls. No sample is taken while a set is being emitted.
// Reset (synchronous, rst_n low): all slot sums read as zero, position and set count
// zero, active_slots = 1, oversample_bits = 0, no result pending.
`default_nettype none
module oversampling_channel_averager import oca_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_room_for_set,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [AVG_W-1:0]            out_average,
  output logic [SLOT_W-1:0]           out_slot,
  output logic                        out_last_of_set,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready
);

  oca_state_t state_r, state_nxt;

  logic [CFG_W-1:0]       active_slots_r, oversample_bits_r;
  slot_idx_t              slot_pos_r, slot_pos_nxt;
  slot_idx_t              emit_idx_r, emit_idx_nxt;
  logic [SET_CNT_W-1:0]   set_cnt_r, set_cnt_nxt;
  logic [MAX_SLOTS-1:0]   valid_r, valid_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   room_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]       out_average_r;
  slot_idx_t              out_slot_r;
  logic                   out_last_r;

  logic [CFG_W-1:0]     n_use, n_m1, k_use;
  logic [SET_CNT_W-1:0] set_cnt_inc, set_thresh;
  logic                 set_end, set_full, emit_last;
  logic                 in_acc, load_out, mem_we, clear_all;
  slot_idx_t            rd_addr;
  sum_t                 rd_data, acc_sum, emit_sum, emit_shifted;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_ACTIVE_SLOTS:    prdata = PDATA_W'(active_slots_r);
      REG_OVERSAMPLE_BITS: prdata = PDATA_W'(oversample_bits_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r    <= CFG_W'(1);
      oversample_bits_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ACTIVE_SLOTS:    active_slots_r    <= pwdata[CFG_W-1:0];
        REG_OVERSAMPLE_BITS: oversample_bits_r <= pwdata[CFG_W-1:0];
        default:             ;
      endcase
    end
  end

  // clamp the live register values
  always_comb begin
    if (active_slots_r == '0) begin
      n_use = CFG_W'(1);
    end else if (active_slots_r > CFG_W'(MAX_SLOTS)) begin
      n_use = CFG_W'(MAX_SLOTS);
    end else begin
      n_use = active_slots_r;
    end
    n_m1 = n_use - CFG_W'(1);
    if (oversample_bits_r > CFG_W'(MAX_OVERSAMPLE_BITS)) begin
      k_use = CFG_W'(MAX_OVERSAMPLE_BITS);
    end else begin
      k_use = oversample_bits_r;
    end
  end

  assign in_acc      = in_valid && in_ready;
  assign acc_sum     = (valid_r[slot_pos_r] ? rd_data : '0) + SUM_BITS'(sample_r);
  assign set_end     = {1'b0, slot_pos_r} >= n_m1;
  assign set_cnt_inc = set_cnt_r + SET_CNT_W'(1);
  assign set_thresh  = SET_CNT_W'(1) << k_use;
  assign set_full    = set_cnt_inc >= set_thresh;
  assign emit_sum    = valid_r[emit_idx_r] ? rd_data : '0;
  assign emit_shifted = emit_sum >> k_use;
  assign emit_last   = {1'b0, emit_idx_r} == n_m1;

  oca_sum_ram u_sum_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_pos_r),
    .wdata (acc_sum),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (set_end && set_full && room_r) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (load_out) begin
          state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    mem_we       = 1'b0;
    load_out     = 1'b0;
    clear_all    = 1'b0;
    rd_addr      = slot_pos_r;
    slot_pos_nxt = slot_pos_r;
    set_cnt_nxt  = set_cnt_r;
    emit_idx_nxt = emit_idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ACCUM: begin
        mem_we = 1'b1;
        if (!set_end) begin
          slot_pos_nxt = slot_pos_r + SLOT_W'(1);
        end else begin
          slot_pos_nxt = '0;
          if (set_full) begin
            set_cnt_nxt  = '0;
            emit_idx_nxt = '0;
            // drop the set when downstream has no room
            clear_all    = !room_r;
          end else begin
            set_cnt_nxt = set_cnt_inc;
          end
        end
      end
      ST_EMIT_RD: begin
        rd_addr = emit_idx_r;
      end
      ST_EMIT_OUT: begin
        // hold the address so the read word stays put during a stall
        rd_addr  = emit_idx_r;
        load_out = !out_valid_r || out_ready;
        if (load_out) begin
          emit_idx_nxt = emit_idx_r + SLOT_W'(1);
          clear_all    = emit_last;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (mem_we) begin
      valid_nxt[slot_pos_r] = 1'b1;
    end
    if (clear_all) begin
      valid_nxt = '0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_pos_r  <= '0;
      emit_idx_r  <= '0;
      set_cnt_r   <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_pos_r  <= slot_pos_nxt;
      emit_idx_r  <= emit_idx_nxt;
      set_cnt_r   <= set_cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
      room_r   <= in_room_for_set;
    end
    if (load_out) begin
      out_average_r <= emit_shifted[AVG_W-1:0];
      out_slot_r    <= emit_idx_r;
      out_last_r    <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_average_r;
  assign out_slot        = out_slot_r;
  assign out_last_of_set = out_last_r;

endmodule
`default_nettype wire
